// ===== rtl/core/lfcb_pkg.sv =====
// Package for the LED fault code blinker: item and configuration types,
// register indexes, reset values and the fixed single-colour pattern tables.
// No dependencies; every other file of the block refers to it by scoped names.
`default_nettype none

package lfcb_pkg;

    // Number of error bits that the block tracks.
    localparam int ERROR_BITS = 8;
    localparam logic [7:0] ERR_MASK = 8'((1 << ERROR_BITS) - 1);

    // Configuration port geometry: 64-bit registers at 8-byte spacing.
    localparam int CFG_ADDR_W = 6;
    localparam int CFG_DATA_W = 64;

    // Register indexes.
    localparam logic [2:0] REG_DUAL_LED    = 3'd0;
    localparam logic [2:0] REG_EXCL_MASK   = 3'd1;
    localparam logic [2:0] REG_CODE_TABLE  = 3'd2;
    localparam logic [2:0] REG_CODE_BLINK  = 3'd3;
    localparam logic [2:0] REG_CODE_GAP    = 3'd4;
    localparam logic [2:0] REG_PAUSE       = 3'd5;

    // Register reset values.
    localparam logic [63:0] CODE_TABLE_RST = 64'h1817_1615_1413_1211;
    localparam logic [15:0] CODE_BLINK_RST = 16'd300;
    localparam logic [15:0] CODE_GAP_RST   = 16'd600;
    localparam logic [15:0] PAUSE_RST      = 16'd1000;

    // Input item kinds.
    localparam logic MODE_TICK  = 1'b0;
    localparam logic MODE_WRITE = 1'b1;

    typedef struct packed {
        logic       mode;
        logic [7:0] error_bits;
    } t_in_item;

    typedef struct packed {
        logic       led_a;
        logic       led_b;
        logic [2:0] shown_index;
        logic       pattern_done;
    } t_out_item;

    typedef struct packed {
        logic        dual_led;
        logic [7:0]  exclusive_mask;
        logic [63:0] code_table;
        logic [15:0] code_blink_ms;
        logic [15:0] code_gap_ms;
        logic [15:0] pattern_pause_ms;
    } t_cfg;

    // Number of toggles for each single-colour pattern id.
    function automatic logic [3:0] max_toggles(input logic [2:0] pid);
        logic [3:0] n;
        case (pid)
            3'd0:    n = 4'd0;
            3'd1:    n = 4'd2;
            3'd2:    n = 4'd4;
            3'd3:    n = 4'd0;
            3'd4:    n = 4'd8;
            3'd5:    n = 4'd4;
            default: n = 4'd0;
        endcase
        return n;
    endfunction

    // Pattern id assigned to each error bit.
    function automatic logic [2:0] bit_pat_id(input logic [2:0] idx);
        logic [2:0] p;
        case (idx)
            3'd0:    p = 3'd1;
            3'd1:    p = 3'd2;
            3'd2:    p = 3'd4;
            3'd3:    p = 3'd5;
            3'd4:    p = 3'd4;
            3'd5:    p = 3'd4;
            3'd6:    p = 3'd1;
            default: p = 3'd2;
        endcase
        return p;
    endfunction

    // Toggle interval in milliseconds for each error bit.
    function automatic logic [10:0] bit_pat_ms(input logic [2:0] idx);
        logic [10:0] ms;
        case (idx)
            3'd0:    ms = 11'd500;
            3'd1:    ms = 11'd150;
            3'd2:    ms = 11'd50;
            3'd3:    ms = 11'd2000;
            3'd4:    ms = 11'd50;
            3'd5:    ms = 11'd100;
            3'd6:    ms = 11'd1000;
            default: ms = 11'd250;
        endcase
        return ms;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/led_fault_code_blinker.sv =====
// Top level of the LED fault code blinker: input register, update core,
// result register and configuration bank. Depends on lfcb_pkg, lfcb_cfg, lfcb_core.
//
//   channel  direction  handshake                         payload
//   input    in         i_in_valid / o_in_ready           i_item  (t_in_item)
//   result   out        o_out_valid / i_out_ready         o_item  (t_out_item)
//   config   in/out     psel penable pwrite / pready      paddr pwdata prdata
//
// Each item gives exactly one result item, via the input and then the result register.
// Unless stalled, one item is accepted per cycle; the state update is one core pass.
// Reset is synchronous and active low; it clears the blinker state and restores
// the register defaults. A stalled result holds in the result register while
// one more item waits in the input register; beyond that o_in_ready drops.
`default_nettype none

module led_fault_code_blinker (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire lfcb_pkg::t_in_item              i_item,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output lfcb_pkg::t_out_item                  o_item,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [lfcb_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [lfcb_pkg::CFG_DATA_W-1:0] pwdata,
    output logic      [lfcb_pkg::CFG_DATA_W-1:0] prdata,
    output logic                                 pready
);

    logic                r_in_valid;
    lfcb_pkg::t_in_item  r_in_item;
    logic                r_out_valid;
    lfcb_pkg::t_out_item r_out_item;
    logic                w_step;
    lfcb_pkg::t_cfg      w_cfg;
    lfcb_pkg::t_out_item w_res;

    // The held item is processed whenever the result register can take its result.
    assign w_step     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_item <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out_item <= w_res;
        end
    end

    lfcb_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    lfcb_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_step  (w_step),
        .i_item  (r_in_item),
        .o_item  (w_res)
    );

    assign o_out_valid = r_out_valid;
    assign o_item      = r_out_item;

    // Every processed item leaves a result in the result register.
    a_step_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_step |=> o_out_valid)
        else $error("processed item left no result");

    // With the result register empty, the input side never stalls.
    a_empty_out_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled while result register empty");

    // A stalled result with an item already waiting holds the input side off.
    a_full_holds_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready && r_in_valid) |-> !o_in_ready)
        else $error("item accepted while both stages are full and stalled");

endmodule

`default_nettype wire

// ===== rtl/core/lfcb_cfg.sv =====
// Configuration register bank of the LED fault code blinker, behind an
// APB-style port with 64-bit data. Depends on lfcb_pkg.
`default_nettype none

module lfcb_cfg (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [lfcb_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [lfcb_pkg::CFG_DATA_W-1:0] pwdata,
    output logic      [lfcb_pkg::CFG_DATA_W-1:0] prdata,
    output logic                                pready,
    output lfcb_pkg::t_cfg                      o_cfg
);

    logic [2:0]     w_index;
    logic           w_write;
    lfcb_pkg::t_cfg r_cfg;

    // Registers sit at 8-byte spacing, so the low three address bits are ignored.
    assign w_index = paddr[lfcb_pkg::CFG_ADDR_W-1:3];
    assign w_write = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dual_led         <= 1'b0;
            r_cfg.exclusive_mask   <= 8'd0;
            r_cfg.code_table       <= lfcb_pkg::CODE_TABLE_RST;
            r_cfg.code_blink_ms    <= lfcb_pkg::CODE_BLINK_RST;
            r_cfg.code_gap_ms      <= lfcb_pkg::CODE_GAP_RST;
            r_cfg.pattern_pause_ms <= lfcb_pkg::PAUSE_RST;
        end else if (w_write) begin
            case (w_index)
                lfcb_pkg::REG_DUAL_LED:   r_cfg.dual_led         <= pwdata[0];
                lfcb_pkg::REG_EXCL_MASK:  r_cfg.exclusive_mask   <= pwdata[7:0];
                lfcb_pkg::REG_CODE_TABLE: r_cfg.code_table       <= pwdata;
                lfcb_pkg::REG_CODE_BLINK: r_cfg.code_blink_ms    <= pwdata[15:0];
                lfcb_pkg::REG_CODE_GAP:   r_cfg.code_gap_ms      <= pwdata[15:0];
                lfcb_pkg::REG_PAUSE:      r_cfg.pattern_pause_ms <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_index)
            lfcb_pkg::REG_DUAL_LED:   prdata = {63'd0, r_cfg.dual_led};
            lfcb_pkg::REG_EXCL_MASK:  prdata = {56'd0, r_cfg.exclusive_mask};
            lfcb_pkg::REG_CODE_TABLE: prdata = r_cfg.code_table;
            lfcb_pkg::REG_CODE_BLINK: prdata = {48'd0, r_cfg.code_blink_ms};
            lfcb_pkg::REG_CODE_GAP:   prdata = {48'd0, r_cfg.code_gap_ms};
            lfcb_pkg::REG_PAUSE:      prdata = {48'd0, r_cfg.pattern_pause_ms};
            default:                  prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== rtl/core/lfcb_core.sv =====
// Blinker state and the single-pass update that one item applies to it.
// The result is combinational; the top level registers it. Depends on lfcb_pkg.
`default_nettype none

module lfcb_core (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire lfcb_pkg::t_cfg     i_cfg,
    input  wire logic               i_step,
    input  wire lfcb_pkg::t_in_item i_item,
    output lfcb_pkg::t_out_item     o_item
);

    // Code phases; the unused code behaves as blink B.
    localparam logic [1:0] PH_A   = 2'd0;
    localparam logic [1:0] PH_GAP = 2'd1;
    localparam logic [1:0] PH_B   = 2'd2;

    // Status flag bit positions.
    localparam int FLG_LED   = 0;
    localparam int FLG_FIRST = 1;
    localparam int FLG_DONE  = 2;

    typedef struct packed {
        logic [31:0] tnow;
        logic [31:0] last;
        logic [31:0] pause;
        logic [7:0]  act;
        logic [2:0]  cur;
        logic [3:0]  fc;
        logic [2:0]  pid;
        logic [10:0] ti;
        logic [1:0]  phase;
        logic [2:0]  flags;
        logic        la;
        logic        lb;
    } t_st;

    t_st        r_st;
    t_st        n_st;
    logic [3:0] w_excl;
    logic [3:0] w_nxt;

    function automatic t_st f_leds(input t_st s, input logic a, input logic b,
                                   input logic two);
        s.flags[FLG_LED] = a;
        s.la = a;
        if (two) begin
            s.lb = b;
        end
        return s;
    endfunction

    function automatic t_st f_start(input t_st s, input logic [2:0] idx,
                                    input logic two);
        if (s.act[idx]) begin
            if (two) begin
                s.phase = PH_A;
                s.fc = 4'd0;
                s.flags[FLG_LED] = 1'b0;
                s.last = s.tnow;
                s = f_leds(s, 1'b0, 1'b0, two);
            end else begin
                s.pid = lfcb_pkg::bit_pat_id(idx);
                s.ti  = lfcb_pkg::bit_pat_ms(idx);
                s.fc  = 4'd0;
                s.flags[FLG_DONE] = 1'b0;
            end
        end
        return s;
    endfunction

    // Lowest active bit that is also marked exclusive; bit 3 flags a hit.
    function automatic logic [3:0] f_excl(input logic [7:0] act, input logic [7:0] mask);
        logic [3:0] r;
        r = 4'd0;
        for (int i = lfcb_pkg::ERROR_BITS - 1; i >= 0; i--) begin
            if (act[i] && mask[i]) begin
                r = {1'b1, 3'(i)};
            end
        end
        return r;
    endfunction

    // Next active bit after cur, wrapping round to cur itself last.
    function automatic logic [3:0] f_next(input logic [7:0] act, input logic [2:0] cur);
        logic [3:0] r;
        logic [2:0] idx;
        r = 4'd0;
        for (int k = 1; k <= lfcb_pkg::ERROR_BITS; k++) begin
            idx = cur + 3'(k);
            if (!r[3] && act[idx]) begin
                r = {1'b1, idx};
            end
        end
        return r;
    endfunction

    function automatic t_st f_end_phase(input t_st s);
        if (s.phase == PH_A) begin
            s.la = 1'b0;
        end else begin
            s.lb = 1'b0;
        end
        s.fc = 4'd0;
        s.last = s.tnow;
        if (s.phase == PH_A) begin
            s.phase = PH_GAP;
        end else begin
            s.flags[FLG_DONE] = 1'b1;
            s.pause = s.tnow;
        end
        return s;
    endfunction

    function automatic t_st f_adv_code(input t_st s, input lfcb_pkg::t_cfg cfg);
        logic [7:0] raw;
        logic [3:0] target;
        logic       ls;
        raw = cfg.code_table[{s.cur, 3'b000} +: 8];
        target = (s.phase == PH_A) ? raw[7:4] : raw[3:0];
        if (s.phase == PH_GAP) begin
            if ((s.tnow - s.last) >= {16'd0, cfg.code_gap_ms}) begin
                s.last = s.tnow;
                s.fc = 4'd0;
                s.phase = PH_B;
            end
        end else if (target == 4'd0) begin
            s = f_end_phase(s);
        end else begin
            if ((s.tnow - s.last) >= {16'd0, cfg.code_blink_ms}) begin
                s.last = s.tnow;
                s.flags[FLG_LED] = ~s.flags[FLG_LED];
                ls = s.flags[FLG_LED];
                if (s.phase == PH_A) begin
                    s.la = ls;
                end else begin
                    s.lb = ls;
                end
                if (!ls) begin
                    s.fc = s.fc + 4'd1;
                end
            end
            if (s.fc >= target) begin
                s = f_end_phase(s);
            end
        end
        return s;
    endfunction

    function automatic t_st f_adv_pat(input t_st s, input lfcb_pkg::t_cfg cfg);
        logic [3:0] maxf;
        maxf = lfcb_pkg::max_toggles(s.pid);
        if (cfg.dual_led) begin
            s = f_adv_code(s, cfg);
        end else begin
            if (s.fc < maxf && (s.tnow - s.last) >= {21'd0, s.ti}) begin
                s.last = s.tnow;
                s.flags[FLG_LED] = ~s.flags[FLG_LED];
                s.la = s.flags[FLG_LED];
                s.fc = s.fc + 4'd1;
            end
            if (s.fc >= maxf) begin
                s = f_leds(s, 1'b0, 1'b0, cfg.dual_led);
                s.flags[FLG_DONE] = 1'b1;
                s.pause = s.tnow;
            end
        end
        return s;
    endfunction

    always_comb begin
        n_st   = r_st;
        w_excl = 4'd0;
        w_nxt  = 4'd0;
        if (i_item.mode == lfcb_pkg::MODE_WRITE) begin
            n_st.act = i_item.error_bits & lfcb_pkg::ERR_MASK;
            n_st = f_start(n_st, n_st.cur, i_cfg.dual_led);
        end else begin
            n_st.tnow = r_st.tnow + 32'd1;
            w_excl = f_excl(n_st.act, i_cfg.exclusive_mask);
            // An exclusive error takes over at once from whatever is shown.
            if (w_excl[3] && w_excl[2:0] != n_st.cur) begin
                n_st.cur = w_excl[2:0];
                n_st.flags[FLG_FIRST] = 1'b0;
                n_st.flags[FLG_DONE]  = 1'b0;
                n_st.fc = 4'd0;
                n_st = f_leds(n_st, 1'b0, 1'b0, i_cfg.dual_led);
            end
            // End of the pause: move on to the next error to show.
            if (n_st.flags[FLG_DONE] &&
                (n_st.tnow - n_st.pause) >= {16'd0, i_cfg.pattern_pause_ms}) begin
                n_st.pause = n_st.tnow;
                n_st = f_leds(n_st, 1'b0, 1'b0, i_cfg.dual_led);
                n_st.flags[FLG_DONE] = 1'b0;
                n_st.fc = 4'd0;
                w_nxt = w_excl[3] ? w_excl : f_next(n_st.act, n_st.cur);
                if (w_nxt[3]) begin
                    n_st.cur = w_nxt[2:0];
                    n_st.flags[FLG_FIRST] = 1'b0;
                    n_st = f_start(n_st, n_st.cur, i_cfg.dual_led);
                end else begin
                    n_st.cur = 3'd0;
                    n_st = f_leds(n_st, 1'b0, 1'b0, i_cfg.dual_led);
                end
            end
            if (!n_st.flags[FLG_DONE]) begin
                if (n_st.act[n_st.cur]) begin
                    if (!n_st.flags[FLG_FIRST]) begin
                        n_st.flags[FLG_FIRST] = 1'b1;
                        n_st = f_start(n_st, n_st.cur, i_cfg.dual_led);
                    end
                    n_st = f_adv_pat(n_st, i_cfg);
                end else begin
                    w_nxt = w_excl[3] ? w_excl : f_next(n_st.act, n_st.cur);
                    if (w_nxt[3]) begin
                        n_st.cur = w_nxt[2:0];
                        n_st.flags[FLG_FIRST] = 1'b0;
                    end else begin
                        n_st.cur = 3'd0;
                        n_st = f_leds(n_st, 1'b0, 1'b0, i_cfg.dual_led);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= '0;
        end else if (i_step) begin
            r_st <= n_st;
        end
    end

    assign o_item.led_a        = n_st.la;
    assign o_item.led_b        = n_st.lb;
    assign o_item.shown_index  = n_st.cur;
    assign o_item.pattern_done = n_st.flags[FLG_DONE];

endmodule

`default_nettype wire

// ===== tb/lfcb_tb_pkg.sv =====
// Cycle-free shadow of the LED fault code blinker, used by the testbench
// to work out the LED levels, shown index and pause flag after every item.
// Depends on lfcb_pkg for the item types, register indexes and reset values.
package lfcb_tb_pkg;

    import lfcb_pkg::*;

    typedef enum bit [1:0] {
        PH_BLINK_A = 2'd0,
        PH_GAP     = 2'd1,
        PH_BLINK_B = 2'd2
    } code_phase_e;

    // Single-colour pattern of each error bit, bit 0 in the lowest slice.
    localparam bit [23:0]  PAT_ID_OF_BIT = {3'd2, 3'd1, 3'd4, 3'd4, 3'd5, 3'd4, 3'd2, 3'd1};
    localparam bit [127:0] PAT_MS_OF_BIT = {16'd250, 16'd1000, 16'd100, 16'd50,
                                            16'd2000, 16'd50, 16'd150, 16'd500};
    // Toggle count per pattern id; ids without an entry give zero.
    localparam bit [31:0]  TOGGLES_OF_PAT = {4'd0, 4'd0, 4'd4, 4'd8, 4'd0, 4'd4, 4'd2, 4'd0};

    class led_shadow;
        bit          dual_led;
        bit [7:0]    excl_mask;
        bit [63:0]   code_tab;
        bit [15:0]   blink_ms;
        bit [15:0]   gap_ms;
        bit [15:0]   pause_ms;

        bit [31:0]   now_ms;
        bit [31:0]   last_toggle;
        bit [31:0]   pause_start;
        bit [7:0]    active;
        bit [2:0]    cur_idx;
        bit [3:0]    flashes;
        bit [2:0]    pat_id;
        bit [15:0]   interval;
        code_phase_e phase;
        bit          toggle_lvl;
        bit          started;
        bit          done;
        bit          led_a;
        bit          led_b;

        t_out_item   expected_leds[$];
        int          failures;
        int          checked;

        function new();
            dual_led    = 1'b0;
            excl_mask   = '0;
            code_tab    = CODE_TABLE_RST;
            blink_ms    = CODE_BLINK_RST;
            gap_ms      = CODE_GAP_RST;
            pause_ms    = PAUSE_RST;
            now_ms      = '0;
            last_toggle = '0;
            pause_start = '0;
            active      = '0;
            cur_idx     = '0;
            flashes     = '0;
            pat_id      = '0;
            interval    = '0;
            phase       = PH_BLINK_A;
            toggle_lvl  = 1'b0;
            started     = 1'b0;
            done        = 1'b0;
            led_a       = 1'b0;
            led_b       = 1'b0;
            failures    = 0;
            checked     = 0;
        endfunction

        function void set_reg(bit [2:0] idx, bit [63:0] value);
            case (idx)
                REG_DUAL_LED:   dual_led  = value[0];
                REG_EXCL_MASK:  excl_mask = value[7:0];
                REG_CODE_TABLE: code_tab  = value;
                REG_CODE_BLINK: blink_ms  = value[15:0];
                REG_CODE_GAP:   gap_ms    = value[15:0];
                REG_PAUSE:      pause_ms  = value[15:0];
                default: ;
            endcase
        endfunction

        function bit [63:0] reg_value(bit [2:0] idx);
            case (idx)
                REG_DUAL_LED:   return 64'(dual_led);
                REG_EXCL_MASK:  return 64'(excl_mask);
                REG_CODE_TABLE: return code_tab;
                REG_CODE_BLINK: return 64'(blink_ms);
                REG_CODE_GAP:   return 64'(gap_ms);
                REG_PAUSE:      return 64'(pause_ms);
                default:        return '0;
            endcase
        endfunction

        // Milliseconds since a stored time stamp, modulo 2^32.
        function bit [31:0] since(bit [31:0] stamp);
            return now_ms - stamp;
        endfunction

        // Second LED is only driven in two-colour mode and otherwise keeps its level.
        function void leds_off();
            toggle_lvl = 1'b0;
            led_a      = 1'b0;
            if (dual_led) led_b = 1'b0;
        endfunction

        function int exclusive_bit();
            for (int i = 0; i < ERROR_BITS; i++) begin
                if (active[i] && excl_mask[i]) return i;
            end
            return -1;
        endfunction

        function int next_active();
            bit [2:0] idx;
            for (int k = 1; k <= ERROR_BITS; k++) begin
                idx = cur_idx + 3'(k);
                if (active[idx]) return int'(idx);
            end
            return -1;
        endfunction

        function void start_pattern(bit [2:0] idx);
            if (!active[idx]) return;
            if (dual_led) begin
                phase       = PH_BLINK_A;
                flashes     = '0;
                last_toggle = now_ms;
                leds_off();
                return;
            end
            pat_id   = PAT_ID_OF_BIT[int'(idx)*3 +: 3];
            interval = PAT_MS_OF_BIT[int'(idx)*16 +: 16];
            flashes  = '0;
            done     = 1'b0;
        endfunction

        function void close_code_phase();
            flashes     = '0;
            last_toggle = now_ms;
            if (phase == PH_BLINK_A) begin
                led_a = 1'b0;
                phase = PH_GAP;
            end else begin
                led_b       = 1'b0;
                done        = 1'b1;
                pause_start = now_ms;
            end
        endfunction

        function void advance_code(bit [2:0] idx);
            bit [7:0] counts;
            bit [3:0] target;
            if (phase == PH_GAP) begin
                if (since(last_toggle) >= 32'(gap_ms)) begin
                    last_toggle = now_ms;
                    flashes     = '0;
                    phase       = PH_BLINK_B;
                end
                return;
            end
            counts = code_tab[int'(idx)*8 +: 8];
            target = (phase == PH_BLINK_A) ? counts[7:4] : counts[3:0];
            // A zero count skips the phase straight away.
            if (target == 0) begin
                close_code_phase();
                return;
            end
            if (since(last_toggle) >= 32'(blink_ms)) begin
                last_toggle = now_ms;
                toggle_lvl  = ~toggle_lvl;
                if (phase == PH_BLINK_A) led_a = toggle_lvl;
                else led_b = toggle_lvl;
                if (!toggle_lvl) flashes++;
            end
            if (flashes >= target) close_code_phase();
        endfunction

        function void advance_pattern(bit [2:0] idx);
            bit [3:0] max_flashes;
            if (dual_led) begin
                advance_code(idx);
                return;
            end
            max_flashes = TOGGLES_OF_PAT[int'(pat_id)*4 +: 4];
            if (flashes < max_flashes && since(last_toggle) >= 32'(interval)) begin
                last_toggle = now_ms;
                toggle_lvl  = ~toggle_lvl;
                led_a       = toggle_lvl;
                flashes++;
            end
            if (flashes >= max_flashes) begin
                leds_off();
                done        = 1'b1;
                pause_start = now_ms;
            end
        endfunction

        function void step_ms();
            int excl;
            int nxt;
            now_ms++;
            excl = exclusive_bit();
            if (excl >= 0 && excl != int'(cur_idx)) begin
                cur_idx = 3'(excl);
                started = 1'b0;
                done    = 1'b0;
                flashes = '0;
                leds_off();
            end
            if (done && since(pause_start) >= 32'(pause_ms)) begin
                pause_start = now_ms;
                leds_off();
                done    = 1'b0;
                flashes = '0;
                nxt = (excl >= 0) ? excl : next_active();
                if (nxt >= 0) begin
                    cur_idx = 3'(nxt);
                    started = 1'b0;
                    start_pattern(cur_idx);
                end else begin
                    cur_idx = '0;
                    leds_off();
                end
            end
            if (!done) begin
                if (active[cur_idx]) begin
                    if (!started) begin
                        started = 1'b1;
                        start_pattern(cur_idx);
                    end
                    advance_pattern(cur_idx);
                end else begin
                    nxt = (excl >= 0) ? excl : next_active();
                    if (nxt >= 0) begin
                        cur_idx = 3'(nxt);
                        started = 1'b0;
                    end else begin
                        cur_idx = '0;
                        leds_off();
                    end
                end
            end
        endfunction

        function void take_item(t_in_item it);
            t_out_item res;
            if (it.mode == MODE_WRITE) begin
                // A write restarts the pattern on show, but never ends a pause
                // in two-colour mode.
                active = it.error_bits & ERR_MASK;
                start_pattern(cur_idx);
            end else begin
                step_ms();
            end
            res.led_a        = led_a;
            res.led_b        = led_b;
            res.shown_index  = cur_idx;
            res.pattern_done = done;
            expected_leds.push_back(res);
        endfunction

        function void check_leds(t_out_item got);
            t_out_item want;
            if (expected_leds.size() == 0) begin
                $error("result item arrived with no input item outstanding");
                failures++;
                return;
            end
            want = expected_leds.pop_front();
            checked++;
            if (got.led_a !== want.led_a) begin
                $error("led_a: expected %0d, got %0d", want.led_a, got.led_a);
                failures++;
            end
            if (got.led_b !== want.led_b) begin
                $error("led_b: expected %0d, got %0d", want.led_b, got.led_b);
                failures++;
            end
            if (got.shown_index !== want.shown_index) begin
                $error("shown_index: expected %0d, got %0d", want.shown_index, got.shown_index);
                failures++;
            end
            if (got.pattern_done !== want.pattern_done) begin
                $error("pattern_done: expected %0d, got %0d", want.pattern_done,
                       got.pattern_done);
                failures++;
            end
        endfunction
    endclass

endpackage

// ===== tb/tb.sv =====
// Testbench top for led_fault_code_blinker: drives ticks and error writes with
// random idling on both channels and checks every result against led_shadow.
// Depends on lfcb_pkg and lfcb_tb_pkg.
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import lfcb_pkg::*;
    import lfcb_tb_pkg::*;

    typedef struct {
        bit        dual_led;
        bit [7:0]  excl;
        bit [63:0] codes;
        bit [15:0] blink;
        bit [15:0] gap;
        bit [15:0] pause;
        int        n_items;
        int        write_pm;  // error writes per thousand items
    } blink_setting_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    t_in_item              in_item = '0;
    logic                  in_ready;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    t_out_item             out_item;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    led_shadow shadow;
    int        items_sent = 0;
    int        in_calm = 0;
    int        out_calm = 0;
    int        stall_left = 0;

    led_fault_code_blinker u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_item      (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_item      (out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Mostly short idle stretches, now and then a long one.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 10);
        return $urandom_range(11, 40);
    endfunction

    function automatic logic [7:0] pick_errors();
        case ($urandom_range(0, 5))
            0:       return 8'h00;
            1:       return 8'hFF;
            2, 3:    return 8'(1 << $urandom_range(0, 7));
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic t_in_item random_item(int write_pm);
        t_in_item it;
        it.mode       = ($urandom_range(0, 999) < write_pm) ? MODE_WRITE : MODE_TICK;
        it.error_bits = pick_errors();
        return it;
    endfunction

    function automatic blink_setting_t setting(bit tc, bit [7:0] ex, bit [63:0] codes,
                                               bit [15:0] bl, bit [15:0] gp, bit [15:0] ps,
                                               int n, int wpm);
        blink_setting_t s;
        s.dual_led  = tc;
        s.excl      = ex;
        s.codes     = codes;
        s.blink     = bl;
        s.gap       = gp;
        s.pause     = ps;
        s.n_items   = n;
        s.write_pm  = wpm;
        return s;
    endfunction

    // Result side: check every accepted result, then decide next cycle's ready.
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) shadow.check_leds(out_item);
        if (stall_left > 0) begin
            stall_left--;
            out_ready <= 1'b0;
        end else if (out_calm > 0) begin
            out_calm--;
            out_ready <= 1'b1;
        end else if ($urandom_range(0, 199) == 0) begin
            out_calm = $urandom_range(30, 150);
            out_ready <= 1'b1;
        end else if ($urandom_range(0, 99) < 25) begin
            stall_left = idle_len() - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    task automatic send_item(input t_in_item it);
        int gap;
        if (in_calm > 0) begin
            in_calm--;
            gap = 0;
        end else begin
            if ($urandom_range(0, 99) == 0) in_calm = $urandom_range(30, 150);
            gap = ($urandom_range(0, 99) < 60) ? 0 : idle_len();
        end
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        shadow.take_item(it);
        items_sent++;
    endtask

    // Registers sit at 8-byte spacing, so the index forms the upper address bits.
    task automatic reg_access(input logic [2:0] idx, input bit wr, input logic [63:0] value,
                              output logic [63:0] rd);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        rd = prdata;
        if (wr) shadow.set_reg(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic check_registers();
        logic [63:0] got;
        logic [2:0]  idx;
        for (int r = 0; r <= int'(REG_PAUSE); r++) begin
            idx = 3'(r);
            reg_access(idx, 1'b0, '0, got);
            if (got !== shadow.reg_value(idx)) begin
                $error("register %0d: expected %h, got %h", idx, shadow.reg_value(idx), got);
                shadow.failures++;
            end
        end
    endtask

    task automatic apply_setting(input blink_setting_t s);
        logic [63:0] unused;
        reg_access(REG_DUAL_LED, 1'b1, 64'(s.dual_led), unused);
        reg_access(REG_EXCL_MASK, 1'b1, 64'(s.excl), unused);
        reg_access(REG_CODE_TABLE, 1'b1, s.codes, unused);
        reg_access(REG_CODE_BLINK, 1'b1, 64'(s.blink), unused);
        reg_access(REG_CODE_GAP, 1'b1, 64'(s.gap), unused);
        reg_access(REG_PAUSE, 1'b1, 64'(s.pause), unused);
    endtask

    // Every item gives a result, so the block is idle once the last one is out.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (shadow.expected_leds.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    initial begin
        blink_setting_t plan[7];
        t_in_item       opening[$];
        shadow = new();
        // Nothing active, all bits, none, the top bit alone (round robin wraps),
        // bit 0 alone, a tick carrying error bits that must be ignored, and a
        // fast pattern left to run for a few milliseconds.
        opening = '{
            {MODE_TICK, 8'h00}, {MODE_WRITE, 8'hFF}, {MODE_TICK, 8'h00}, {MODE_TICK, 8'h00},
            {MODE_WRITE, 8'h00}, {MODE_TICK, 8'h00}, {MODE_WRITE, 8'h80}, {MODE_TICK, 8'h00},
            {MODE_TICK, 8'h00}, {MODE_WRITE, 8'h01}, {MODE_TICK, 8'hFF}, {MODE_WRITE, 8'hAA},
            {MODE_TICK, 8'h55}, {MODE_TICK, 8'h00}, {MODE_TICK, 8'h00}, {MODE_WRITE, 8'h04},
            {MODE_TICK, 8'h00}, {MODE_TICK, 8'h00}, {MODE_TICK, 8'h00}, {MODE_TICK, 8'h00},
            {MODE_TICK, 8'h00}, {MODE_WRITE, 8'h7F}
        };
        plan[0] = setting(1'b0, 8'h00, CODE_TABLE_RST, CODE_BLINK_RST, CODE_GAP_RST,
                          PAUSE_RST, 150, 20);
        plan[1] = setting(1'b0, 8'h00, {$urandom, $urandom}, 16'($urandom),
                          16'($urandom), 16'h0000, 550, 4);
        plan[2] = setting(1'b1, 8'h00, {$urandom, $urandom} & {$urandom, $urandom},
                          16'd1, 16'd2, 16'd3, 150, 30);
        plan[3] = setting(1'b1, 8'hFF, 64'h0, 16'h0000, 16'h0000, 16'h0000, 100, 60);
        plan[4] = setting(1'b1, 8'($urandom), 64'hFFFF_FFFF_FFFF_FFFF, 16'h0000,
                          16'd1, 16'd2, 200, 15);
        plan[5] = setting(1'b1, 8'h24, {$urandom, $urandom}, 16'hFFFF, 16'hFFFF,
                          16'hFFFF, 80, 40);
        plan[6] = setting(1'b0, 8'($urandom), {$urandom, $urandom}, 16'($urandom),
                          16'($urandom), 16'd5, 550, 4);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        check_registers();
        foreach (opening[k]) send_item(opening[k]);
        for (int p = 0; p < 7; p++) begin
            if (p > 0) begin
                apply_setting(plan[p]);
                check_registers();
            end
            repeat (plan[p].n_items) send_item(random_item(plan[p].write_pm));
            drain_results();
        end

        $display("Sent %0d items over seven register settings in both LED modes;", items_sent);
        $display("%0d results compared, %0d mismatches.", shadow.checked, shadow.failures);
        if (shadow.failures == 0) begin
            $display("** led_fault_code_blinker: PASSED **");
        end else begin
            $display("** led_fault_code_blinker: FAILED **");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("Run did not complete in time.");
        $display("** led_fault_code_blinker: FAILED **");
        $finish;
    end

endmodule

// ===== led_fault_code_blinker.f =====
rtl/core/lfcb_pkg.sv
rtl/core/lfcb_cfg.sv
rtl/core/lfcb_core.sv
rtl/core/led_fault_code_blinker.sv
tb/lfcb_tb_pkg.sv
tb/tb.sv
